@@ design/stereo_three_band_biquad_eq_assert.svh @@
// assertion macros used by the equalizer sequencer
`ifndef STEREO_THREE_BAND_BIQUAD_EQ_ASSERT_SVH
`define STEREO_THREE_BAND_BIQUAD_EQ_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define SBEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define SBEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sbeq_pkg.sv @@
// shared types, constants and coefficient unpacking for the equalizer
package sbeq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int HIST_W    = 32;
  localparam int IN_SH     = 8;
  localparam int B_W       = 21;
  localparam int A_W       = 31;
  localparam int BREG_W    = 3 * B_W;
  localparam int AREG_W    = 2 * A_W;
  localparam int CFG_W     = BREG_W;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_BANDS = 3;
  localparam int BAND_W    = 2;
  localparam int COEF_W    = 32;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int ACC_W     = 56;
  localparam int A_SH      = 11;
  localparam int FRAC_SH   = 18;
  localparam int STEP_W    = 3;

  localparam logic [BREG_W-1:0] B_RESET = BREG_W'(262144);
  localparam logic [AREG_W-1:0] A_RESET = '0;

  // step of one band pass: five products, the last accumulate, one closing step
  localparam logic [STEP_W-1:0] STEP_X0     = 3'd0;
  localparam logic [STEP_W-1:0] STEP_X1     = 3'd1;
  localparam logic [STEP_W-1:0] STEP_X2     = 3'd2;
  localparam logic [STEP_W-1:0] STEP_Y1     = 3'd3;
  localparam logic [STEP_W-1:0] STEP_Y2     = 3'd4;
  localparam logic [STEP_W-1:0] STEP_LAST_A = 3'd5;
  localparam logic [STEP_W-1:0] STEP_COMMIT = 3'd6;

  localparam logic [BAND_W-1:0] BAND_FIRST = 2'd0;
  localparam logic [BAND_W-1:0] BAND_LAST  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASS_B   = 3'd0,
    REG_BASS_A   = 3'd1,
    REG_MID_B    = 3'd2,
    REG_MID_A    = 3'd3,
    REG_TREBLE_B = 3'd4,
    REG_TREBLE_A = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  // control from the sequencer to both lanes and the output stage
  typedef struct packed {
    logic                     load;
    logic                     mul_en;
    logic [STEP_W-1:0]        opsel;
    logic signed [COEF_W-1:0] coef;
    logic                     acc_en;
    logic                     acc_first;
    logic                     acc_sub;
    logic                     commit;
    logic                     out_load;
  } ctrl_t;

  // coefficient of one product, sign extended to the multiplier width
  function automatic logic signed [COEF_W-1:0] coef_of(
    input logic [BREG_W-1:0] b,
    input logic [AREG_W-1:0] a,
    input logic [STEP_W-1:0] step
  );
    logic [B_W-1:0] bf;
    logic [A_W-1:0] af;
    logic signed [COEF_W-1:0] c;
    bf = '0;
    af = '0;
    c  = '0;
    case (step)
      STEP_X0: begin
        bf = b[B_W-1:0];
        c  = {{(COEF_W-B_W){bf[B_W-1]}}, bf};
      end
      STEP_X1: begin
        bf = b[2*B_W-1:B_W];
        c  = {{(COEF_W-B_W){bf[B_W-1]}}, bf};
      end
      STEP_X2: begin
        bf = b[3*B_W-1:2*B_W];
        c  = {{(COEF_W-B_W){bf[B_W-1]}}, bf};
      end
      STEP_Y1: begin
        af = a[A_W-1:0];
        c  = {{(COEF_W-A_W){af[A_W-1]}}, af};
      end
      STEP_Y2: begin
        af = a[2*A_W-1:A_W];
        c  = {{(COEF_W-A_W){af[A_W-1]}}, af};
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ design/sbeq_if.sv @@
// request channels of the equalizer: stereo frames in, equalized frames out
interface sbeq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sbeq_pkg::SAMPLE_W-1:0] left_in;
  logic signed [sbeq_pkg::SAMPLE_W-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sbeq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sbeq_pkg::SAMPLE_W-1:0] left_out;
  logic signed [sbeq_pkg::SAMPLE_W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

@@ design/stereo_three_band_biquad_eq.sv @@
// stereo three-band biquad equalizer, top level
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    left_in, right_in     (signed 16)
//   out_o    out  valid / ready    left_out, right_out   (signed 16)
//   cfg      in   cfg_we_i         cfg_idx_i, cfg_data_i (63 bits)
//
// a frame is accepted, then runs 3 bands x 7 steps per lane
// (five products on one 32x32 multiplier, a last accumulate, a closing step)
// the left and right lanes run together; the result register loads on the
// last band step and a new request is taken in the cycle after
// if the result register is still full, the lanes hold until it is taken
// reset clears the history, the coefficients to passthrough, and all valids
module stereo_three_band_biquad_eq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sbeq_in_if.sink                             in_i,
  sbeq_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [sbeq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sbeq_pkg::CFG_W-1:0]          cfg_data_i
);
  import sbeq_pkg::*;

  logic [NUM_BANDS-1:0][BREG_W-1:0] b_coeffs_q;
  logic [NUM_BANDS-1:0][AREG_W-1:0] a_coeffs_q;
  ctrl_t                            ctrl;
  logic                             out_free;
  logic signed [HIST_W-1:0]         left_y;
  logic signed [HIST_W-1:0]         right_y;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        b_coeffs_q[i] <= B_RESET;
        a_coeffs_q[i] <= A_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BASS_B:   b_coeffs_q[0] <= cfg_data_i[BREG_W-1:0];
        REG_BASS_A:   a_coeffs_q[0] <= cfg_data_i[AREG_W-1:0];
        REG_MID_B:    b_coeffs_q[1] <= cfg_data_i[BREG_W-1:0];
        REG_MID_A:    a_coeffs_q[1] <= cfg_data_i[AREG_W-1:0];
        REG_TREBLE_B: b_coeffs_q[2] <= cfg_data_i[BREG_W-1:0];
        REG_TREBLE_A: a_coeffs_q[2] <= cfg_data_i[AREG_W-1:0];
        default: ;
      endcase
    end
  end

  // band and step sequencer
  sbeq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_free_i (out_free),
    .b_coeffs_i (b_coeffs_q),
    .a_coeffs_i (a_coeffs_q),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl)
  );

  // left and right lanes
  sbeq_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (in_i.left_in),
    .y_o      (left_y)
  );

  sbeq_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (in_i.right_in),
    .y_o      (right_y)
  );

  // merge into the output request
  sbeq_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (ctrl.out_load),
    .left_y_i  (left_y),
    .right_y_i (right_y),
    .free_o    (out_free),
    .out_o     (out_o)
  );

endmodule

@@ design/sbeq_lane.sv @@
// one channel lane: multiply-accumulate core and rotating band history
module sbeq_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sbeq_pkg::ctrl_t                      ctrl_i,
  input  logic signed [sbeq_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [sbeq_pkg::HIST_W-1:0]   y_o
);
  import sbeq_pkg::*;

  localparam int SUM_W = ACC_W - FRAC_SH;
  localparam int HX1   = 0;
  localparam int HX2   = 1;
  localparam int HY1   = 2;
  localparam int HY2   = 3;

  // slot 0 always holds the band being worked on
  logic signed [HIST_W-1:0] hist_q [NUM_BANDS][4];
  logic signed [HIST_W-1:0] x_cur_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  term;
  logic signed [HIST_W-1:0] operand;
  logic signed [SUM_W-1:0]  sum;
  logic signed [HIST_W-1:0] y_sat;

  // operand of the current product
  always_comb begin
    case (ctrl_i.opsel)
      STEP_X0: operand = x_cur_q;
      STEP_X1: operand = hist_q[0][HX1];
      STEP_X2: operand = hist_q[0][HX2];
      STEP_Y1: operand = hist_q[0][HY1];
      STEP_Y2: operand = hist_q[0][HY2];
      default: operand = '0;
    endcase
  end

  assign prod_d  = $signed(ctrl_i.coef) * operand;
  assign prod_sh = prod_q >>> A_SH;

  // feedback products are floored to the feedforward scale and subtracted
  always_comb begin
    if (ctrl_i.acc_sub) begin
      term = -$signed(prod_sh[ACC_W-1:0]);
    end else begin
      term = $signed(prod_q[ACC_W-1:0]);
    end
  end

  assign acc_d = (ctrl_i.acc_first ? '0 : acc_q) + term;

  // floor to Q24.8 and saturate to 32 bits
  assign sum = $signed(acc_q[ACC_W-1:FRAC_SH]);

  always_comb begin
    if (sum[SUM_W-1:HIST_W-1] == '0 || sum[SUM_W-1:HIST_W-1] == '1) begin
      y_sat = sum[HIST_W-1:0];
    end else if (sum[SUM_W-1]) begin
      y_sat = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(HIST_W-1){1'b1}}};
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.load) begin
      x_cur_q <= {{(HIST_W-SAMPLE_W-IN_SH){sample_i[SAMPLE_W-1]}}, sample_i,
                  {IN_SH{1'b0}}};
    end else if (ctrl_i.commit) begin
      x_cur_q <= y_sat;
    end
  end

  // history: update the finished band and rotate the next one into slot 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        for (int j = 0; j < 4; j++) begin
          hist_q[i][j] <= '0;
        end
      end
    end else if (ctrl_i.commit) begin
      for (int i = 0; i < NUM_BANDS - 1; i++) begin
        hist_q[i] <= hist_q[i+1];
      end
      hist_q[NUM_BANDS-1][HX1] <= x_cur_q;
      hist_q[NUM_BANDS-1][HX2] <= hist_q[0][HX1];
      hist_q[NUM_BANDS-1][HY1] <= y_sat;
      hist_q[NUM_BANDS-1][HY2] <= hist_q[0][HY1];
    end
  end

  // the treble result is visible in its closing cycle and held after
  assign y_o = ctrl_i.commit ? y_sat : x_cur_q;

endmodule

@@ design/sbeq_ctrl.sv @@
// sequencer: steps both lanes through three bands of five products each
`include "stereo_three_band_biquad_eq_assert.svh"

module sbeq_ctrl (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   in_valid_i,
  input  logic                                                   out_free_i,
  input  logic [sbeq_pkg::NUM_BANDS-1:0][sbeq_pkg::BREG_W-1:0]   b_coeffs_i,
  input  logic [sbeq_pkg::NUM_BANDS-1:0][sbeq_pkg::AREG_W-1:0]   a_coeffs_i,
  output logic                                                   in_ready_o,
  output sbeq_pkg::ctrl_t                                        ctrl_o
);
  import sbeq_pkg::*;

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [BAND_W-1:0]   band_q, band_d;
  logic                in_fire;
  logic                last_commit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign last_commit = (state_q == ST_RUN) && (step_q == STEP_COMMIT) && (band_q == BAND_LAST);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (last_commit) state_d = out_free_i ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // step and band counters
  always_comb begin
    step_d = step_q;
    band_d = band_q;
    if (in_fire) begin
      step_d = STEP_X0;
      band_d = BAND_FIRST;
    end else if (state_q == ST_RUN) begin
      if (step_q == STEP_COMMIT) begin
        step_d = STEP_X0;
        band_d = (band_q == BAND_LAST) ? BAND_FIRST : band_q + 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_X0;
      band_q  <= BAND_FIRST;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      band_q  <= band_d;
    end
  end

  // control outputs
  always_comb begin
    ctrl_o           = '0;
    ctrl_o.load      = in_fire;
    ctrl_o.opsel     = step_q;
    ctrl_o.coef      = coef_of(b_coeffs_i[band_q], a_coeffs_i[band_q], step_q);
    ctrl_o.acc_first = (step_q == STEP_X1);
    ctrl_o.acc_sub   = (step_q == STEP_Y2) || (step_q == STEP_LAST_A);
    if (state_q == ST_RUN) begin
      ctrl_o.mul_en = (step_q <= STEP_Y2);
      ctrl_o.acc_en = (step_q >= STEP_X1) && (step_q <= STEP_LAST_A);
      ctrl_o.commit = (step_q == STEP_COMMIT);
    end
    ctrl_o.out_load = (last_commit && out_free_i) || ((state_q == ST_HOLD) && out_free_i);
  end

  `SBEQ_ASSERT_NXT(a_fire_starts, clk_i, rst_ni, in_fire, (state_q == ST_RUN) && (step_q == STEP_X0) && (band_q == BAND_FIRST), "frame did not start at the first band")
  `SBEQ_ASSERT_NXT(a_last_leaves_run, clk_i, rst_ni, last_commit, state_q != ST_RUN, "sequencer stayed busy after the treble band")
  `SBEQ_ASSERT_IMP(a_load_needs_room, clk_i, rst_ni, ctrl_o.out_load, out_free_i, "result loaded while the output register was full")
  `SBEQ_ASSERT_IMP(a_no_work_idle, clk_i, rst_ni, state_q != ST_RUN, !ctrl_o.commit && !ctrl_o.acc_en && !ctrl_o.mul_en, "lane work outside a running frame")

endmodule

@@ design/sbeq_out.sv @@
// merge stage: converts both lane results to PCM and holds the output request
module sbeq_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic signed [sbeq_pkg::HIST_W-1:0] left_y_i,
  input  logic signed [sbeq_pkg::HIST_W-1:0] right_y_i,
  output logic                               free_o,
  sbeq_out_if.source                         out_o
);
  import sbeq_pkg::*;

  localparam int T_W = HIST_W + 1 - IN_SH;

  logic                       valid_q;
  logic signed [SAMPLE_W-1:0] left_q;
  logic signed [SAMPLE_W-1:0] right_q;

  // drop the fraction toward zero, then clamp to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] to_pcm(input logic signed [HIST_W-1:0] y);
    logic signed [HIST_W:0] y_ext;
    logic signed [HIST_W:0] adj;
    logic signed [T_W-1:0]  t;
    logic signed [SAMPLE_W-1:0] r;
    y_ext = {y[HIST_W-1], y};
    adj   = y[HIST_W-1] ? y_ext + (HIST_W+1)'((1 << IN_SH) - 1) : y_ext;
    t     = adj[HIST_W:IN_SH];
    if (t[T_W-1:SAMPLE_W-1] == '0 || t[T_W-1:SAMPLE_W-1] == '1) begin
      r = t[SAMPLE_W-1:0];
    end else if (t[T_W-1]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign free_o = !valid_q || out_o.ready;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      left_q  <= to_pcm(left_y_i);
      right_q <= to_pcm(right_y_i);
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.left_out  = left_q;
  assign out_o.right_out = right_q;

endmodule
